// ===== hw/rtl/bilinear_quad_shape_functions_top_macros.svh =====
// Assertion macros for the quad shape function block
`ifndef BILINEAR_QUAD_SHAPE_FUNCTIONS_TOP_MACROS_SVH
`define BILINEAR_QUAD_SHAPE_FUNCTIONS_TOP_MACROS_SVH

// Condition holds, property holds in the same cycle
`define QSF_ASSERT_IMP(name, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Condition holds, property holds in the following cycle
`define QSF_ASSERT_NXT(name, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== hw/rtl/qsf_pkg.sv =====
// Shared widths, constants, types and helpers of the quad shape function block
`default_nettype none
package qsf_pkg;

    localparam int QSF_NODES   = 4;
    localparam int NAT_W       = 18;
    localparam int COORD_W     = 24;
    localparam int AB_W        = 18;
    localparam int LD_W        = 19;
    localparam int JP_W        = 43;
    localparam int JS_W        = 45;
    localparam int JAC_W       = 33;
    localparam int DP_W        = 66;
    localparam int PROD_W      = 64;
    localparam int DET_W       = 49;
    localparam int DETO_W      = 48;
    localparam int NP_W        = 52;
    localparam int NUM_W       = 51;
    localparam int DEN_W       = 50;
    localparam int SHAPE_W     = 17;
    localparam int DERIV_W     = 40;
    localparam int DIV_STEPS   = 40;
    localparam int DIV_LAT     = DIV_STEPS + 2;
    localparam int IN_TDATA_W  = 232;
    localparam int OUT_TDATA_W = 152;
    localparam int OUT_USED_W  = 2 + SHAPE_W + 2 * DERIV_W + DETO_W;

    localparam int IN_S_LSB    = 0;
    localparam int IN_T_LSB    = 18;
    localparam int IN_C_LSB    = 36;
    localparam int IN_C_STRIDE = 48;

    localparam int JAC_SHIFT   = 10;
    localparam int DET_SHIFT   = 16;

    localparam logic signed [NAT_W-1:0] NAT_ONE  = 18'sd65536;
    localparam logic signed [NAT_W-1:0] NAT_MONE = -18'sd65536;
    localparam logic [1:0]              NODE_0    = 2'd0;
    localparam logic [1:0]              NODE_1    = 2'd1;
    localparam logic [1:0]              NODE_LAST = 2'd3;

    typedef struct packed {
        logic signed [JP_W-1:0] xs;
        logic signed [JP_W-1:0] xt;
        logic signed [JP_W-1:0] ys;
        logic signed [JP_W-1:0] yt;
    } jprod_t;

    typedef struct packed {
        logic signed [JAC_W-1:0] xs;
        logic signed [JAC_W-1:0] xt;
        logic signed [JAC_W-1:0] ys;
        logic signed [JAC_W-1:0] yt;
    } jac_t;

    typedef struct packed {
        logic [SHAPE_W-1:0] shape;
        logic [NUM_W-1:0]   ax;
        logic               negx;
        logic [NUM_W-1:0]   ay;
        logic               negy;
    } lane_out_t;

    // Node natural positions: 0 (-1,-1), 1 (+1,-1), 2 (+1,+1), 3 (-1,+1)
    function automatic logic node_s_neg(input logic [1:0] n);
        return (n == NODE_0) || (n == NODE_LAST);
    endfunction

    function automatic logic node_t_neg(input logic [1:0] n);
        return (n == NODE_0) || (n == NODE_1);
    endfunction

    // Q26 to Q16, half away from zero
    function automatic logic signed [JAC_W-1:0] round_jac(input logic signed [JS_W-1:0] v);
        logic [JS_W-1:0] m;
        logic [JS_W-1:0] r;
        m = v[JS_W-1] ? JS_W'(-v) : JS_W'(v);
        r = (m + (JS_W'(1) << (JAC_SHIFT - 1))) >> JAC_SHIFT;
        return v[JS_W-1] ? -JAC_W'(r) : JAC_W'(r);
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bilinear_quad_shape_functions_top.sv =====
// Each accepted request yields four node results, node 0 first and nodes 1..3 after it.
// Requests overlap in the front stages, which stall while a finished request waits for the
// serialiser. Past the node lanes all nodes share one path, one node result per cycle
// while the skid entry is empty, through two quotient units that are 42-stage pipelines.
// Reset empties every stage and the output register; no result is pending after reset.
`default_nettype none
`include "bilinear_quad_shape_functions_top_macros.svh"
module bilinear_quad_shape_functions_top
    import qsf_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // nat_s, nat_t, corner0_x, corner0_y, corner1_x, corner1_y,
    // corner2_x, corner2_y, corner3_x, corner3_y
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // node_index, shape_value, deriv_x, deriv_y, jacobian_det
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // singular
    output logic                        m_axis_tuser,
    output logic                        m_axis_tlast
);

    localparam int ITEM_STAGES = 9;

    typedef struct packed {
        logic [1:0]         node;
        logic [SHAPE_W-1:0] shape;
        logic [DETO_W-1:0]  det;
        logic               sing;
        logic               last;
    } side_t;

    typedef struct packed {
        logic [1:0]                node;
        logic [SHAPE_W-1:0]        shape;
        logic signed [DERIV_W-1:0] dx;
        logic signed [DERIV_W-1:0] dy;
        logic [DETO_W-1:0]         det;
        logic                      sing;
        logic                      last;
    } result_t;

    logic                      pipe_en;
    logic                      item_en;
    logic [ITEM_STAGES-1:0]    v_reg;
    logic [ITEM_STAGES-1:0]    v_next;

    logic signed [NAT_W-1:0]   s_raw;
    logic signed [NAT_W-1:0]   t_raw;
    logic signed [NAT_W-1:0]   s0_reg;
    logic signed [NAT_W-1:0]   t0_reg;
    logic signed [COORD_W-1:0] cx0_reg [QSF_NODES];
    logic signed [COORD_W-1:0] cy0_reg [QSF_NODES];

    jprod_t                    jprod_w [QSF_NODES];
    lane_out_t                 lane_w  [QSF_NODES];
    jac_t                      js_sum;
    logic signed [JS_W-1:0]    js3_xs_reg;
    logic signed [JS_W-1:0]    js3_xt_reg;
    logic signed [JS_W-1:0]    js3_ys_reg;
    logic signed [JS_W-1:0]    js3_yt_reg;
    logic signed [JS_W-1:0]    sum_xs;
    logic signed [JS_W-1:0]    sum_xt;
    logic signed [JS_W-1:0]    sum_ys;
    logic signed [JS_W-1:0]    sum_yt;
    jac_t                      jac4_reg;
    logic signed [DP_W-1:0]    dp1_reg;
    logic signed [DP_W-1:0]    dp2_reg;
    logic signed [DP_W-1:0]    dp_diff;
    logic [PROD_W-1:0]         prod6_reg;
    logic [PROD_W-1:0]         prod_mag;
    logic [PROD_W-1:0]         prod_rnd;
    logic signed [DET_W-1:0]   det7_reg;
    logic [DETO_W-1:0]         det7_mag;
    logic [DEN_W-1:0]          b8_reg;
    logic [DETO_W-1:0]         det8_reg;
    logic                      sing8_reg;

    lane_out_t                 ser_lane_reg [QSF_NODES];
    logic [DEN_W-1:0]          ser_b_reg;
    logic [DETO_W-1:0]         ser_det_reg;
    logic                      ser_sing_reg;
    logic                      ser_valid_reg;
    logic                      ser_valid_next;
    logic [1:0]                ser_cnt_reg;
    logic [1:0]                ser_cnt_next;
    logic                      ser_load;
    lane_out_t                 ser_sel;

    side_t                     sb_reg   [DIV_LAT];
    logic [DIV_LAT-1:0]        sb_v_reg;
    logic signed [DERIV_W-1:0] dx_w;
    logic signed [DERIV_W-1:0] dy_w;
    result_t                   pipe_res;

    result_t                   out_reg;
    result_t                   out_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    result_t                   skid_reg;
    result_t                   skid_next;
    logic                      skid_valid_reg;
    logic                      skid_valid_next;

    // Holds while the skid stage is occupied; the item stages also wait on the serialiser
    assign pipe_en  = !skid_valid_reg;
    assign ser_load = item_en && v_reg[ITEM_STAGES-1];
    assign item_en  = pipe_en &&
                      (!v_reg[ITEM_STAGES-1] || !ser_valid_reg || (ser_cnt_reg == NODE_LAST));
    assign s_axis_tready = item_en;

    always_comb
    begin
        v_next = {v_reg[ITEM_STAGES-2:0], s_axis_tvalid};
    end

    always_comb
    begin
        s_raw = signed'(s_axis_tdata[IN_S_LSB +: NAT_W]);
        t_raw = signed'(s_axis_tdata[IN_T_LSB +: NAT_W]);
    end

    always_ff @(posedge clk)
    begin
        if (item_en)
        begin
            s0_reg <= (s_raw > NAT_ONE) ? NAT_ONE : ((s_raw < NAT_MONE) ? NAT_MONE : s_raw);
            t0_reg <= (t_raw > NAT_ONE) ? NAT_ONE : ((t_raw < NAT_MONE) ? NAT_MONE : t_raw);
            for (int k = 0; k < QSF_NODES; k++)
            begin
                cx0_reg[k] <= signed'(s_axis_tdata[IN_C_LSB + IN_C_STRIDE*k +: COORD_W]);
                cy0_reg[k] <= signed'(s_axis_tdata[IN_C_LSB + IN_C_STRIDE*k + COORD_W +: COORD_W]);
            end
        end
    end

    for (genvar k = 0; k < QSF_NODES; k++)
    begin : g_lane
        qsf_lane u_lane (
            .clk     (clk),
            .en      (item_en),
            .node_id (2'(k)),
            .s       (s0_reg),
            .t       (t0_reg),
            .cx      (cx0_reg[k]),
            .cy      (cy0_reg[k]),
            .jac     (jac4_reg),
            .det     (det7_reg),
            .jprod   (jprod_w[k]),
            .res     (lane_w[k])
        );
    end

    // Merge the lane products into the Jacobian
    always_comb
    begin
        sum_xs = '0;
        sum_xt = '0;
        sum_ys = '0;
        sum_yt = '0;
        for (int k = 0; k < QSF_NODES; k++)
        begin
            sum_xs = sum_xs + JS_W'(jprod_w[k].xs);
            sum_xt = sum_xt + JS_W'(jprod_w[k].xt);
            sum_ys = sum_ys + JS_W'(jprod_w[k].ys);
            sum_yt = sum_yt + JS_W'(jprod_w[k].yt);
        end
    end

    always_comb
    begin
        js_sum.xs = round_jac(js3_xs_reg);
        js_sum.xt = round_jac(js3_xt_reg);
        js_sum.ys = round_jac(js3_ys_reg);
        js_sum.yt = round_jac(js3_yt_reg);
        dp_diff   = dp1_reg - dp2_reg;
        prod_mag  = prod6_reg[PROD_W-1] ? (PROD_W'(0) - prod6_reg) : prod6_reg;
        prod_rnd  = (prod_mag + (PROD_W'(1) << (DET_SHIFT - 1))) >> DET_SHIFT;
        det7_mag  = det7_reg[DET_W-1] ? DETO_W'(-det7_reg) : DETO_W'(det7_reg);
    end

    always_ff @(posedge clk)
    begin
        if (item_en)
        begin
            js3_xs_reg <= sum_xs;
            js3_xt_reg <= sum_xt;
            js3_ys_reg <= sum_ys;
            js3_yt_reg <= sum_yt;
            jac4_reg   <= js_sum;
            dp1_reg    <= DP_W'(jac4_reg.xs) * DP_W'(jac4_reg.yt);
            dp2_reg    <= DP_W'(jac4_reg.xt) * DP_W'(jac4_reg.ys);
            // determinant product wraps at 64 bits
            prod6_reg  <= dp_diff[PROD_W-1:0];
            det7_reg   <= prod6_reg[PROD_W-1] ? -DET_W'(prod_rnd[DETO_W-1:0])
                                              : DET_W'(prod_rnd[DETO_W-1:0]);
            b8_reg     <= (det7_reg == '0) ? DEN_W'(1) : {det7_mag, 2'b00};
            det8_reg   <= det7_reg[DETO_W-1:0];
            sing8_reg  <= det7_reg == '0;
        end
    end

    // Serialise the four node results, one per cycle while the skid entry is empty
    always_comb
    begin
        ser_sel        = ser_lane_reg[ser_cnt_reg];
        ser_valid_next = ser_valid_reg;
        ser_cnt_next   = ser_cnt_reg;
        if (pipe_en && ser_valid_reg)
        begin
            if (ser_cnt_reg == NODE_LAST)
            begin
                ser_valid_next = 1'b0;
            end
            else
            begin
                ser_cnt_next = ser_cnt_reg + 2'd1;
            end
        end
        if (ser_load)
        begin
            ser_valid_next = 1'b1;
            ser_cnt_next   = NODE_0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ser_load)
        begin
            for (int k = 0; k < QSF_NODES; k++)
            begin
                ser_lane_reg[k] <= lane_w[k];
            end
            ser_b_reg    <= b8_reg;
            ser_det_reg  <= det8_reg;
            ser_sing_reg <= sing8_reg;
        end
    end

    qsf_div u_div_x (
        .clk (clk),
        .en  (pipe_en),
        .num (ser_sel.ax),
        .den (ser_b_reg),
        .neg (ser_sel.negx),
        .quo (dx_w)
    );

    qsf_div u_div_y (
        .clk (clk),
        .en  (pipe_en),
        .num (ser_sel.ay),
        .den (ser_b_reg),
        .neg (ser_sel.negy),
        .quo (dy_w)
    );

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            sb_reg[0].node  <= ser_cnt_reg;
            sb_reg[0].shape <= ser_sel.shape;
            sb_reg[0].det   <= ser_det_reg;
            sb_reg[0].sing  <= ser_sing_reg;
            sb_reg[0].last  <= ser_cnt_reg == NODE_LAST;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                sb_reg[i] <= sb_reg[i-1];
            end
        end
    end

    always_comb
    begin
        pipe_res.node  = sb_reg[DIV_LAT-1].node;
        pipe_res.shape = sb_reg[DIV_LAT-1].shape;
        pipe_res.dx    = dx_w;
        pipe_res.dy    = dy_w;
        pipe_res.det   = sb_reg[DIV_LAT-1].det;
        pipe_res.sing  = sb_reg[DIV_LAT-1].sing;
        pipe_res.last  = sb_reg[DIV_LAT-1].last;
    end

    // Output register with one skid entry behind it
    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (pipe_en)
        begin
            if (sb_v_reg[DIV_LAT-1])
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_next       = pipe_res;
                    out_valid_next = 1'b1;
                end
                else
                begin
                    skid_next       = pipe_res;
                    skid_valid_next = 1'b1;
                end
            end
            else if (m_axis_tready)
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (m_axis_tready)
        begin
            out_next        = skid_reg;
            skid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg          <= '0;
            ser_valid_reg  <= 1'b0;
            ser_cnt_reg    <= NODE_0;
            sb_v_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_en)
            begin
                v_reg <= v_next;
            end
            ser_valid_reg <= ser_valid_next;
            ser_cnt_reg   <= ser_cnt_next;
            if (pipe_en)
            begin
                sb_v_reg <= {sb_v_reg[DIV_LAT-2:0], ser_valid_reg};
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - OUT_USED_W)'(0), out_reg.det, out_reg.dy, out_reg.dx,
                            out_reg.shape, out_reg.node};
    assign m_axis_tuser  = out_reg.sing;
    assign m_axis_tlast  = out_reg.last;

    `QSF_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid entry without output")
    `QSF_ASSERT_IMP(a_no_take_on_hold, s_axis_tready, !skid_valid_reg, "request taken on hold")
    `QSF_ASSERT_IMP(a_singular_zero, out_valid_reg && out_reg.sing,
                    out_reg.dx == '0 && out_reg.dy == '0,
                    "singular result with nonzero derivative")
    `QSF_ASSERT_IMP(a_last_is_node3, out_valid_reg,
                    out_reg.last == (out_reg.node == NODE_LAST), "last flag off node 3")

endmodule
`default_nettype wire

// ===== hw/rtl/qsf_lane.sv =====
// One node lane: shape value, local derivatives and adjugate products
`default_nettype none
module qsf_lane
    import qsf_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      en,
    input  wire logic [1:0]                node_id,
    input  wire logic signed [NAT_W-1:0]   s,
    input  wire logic signed [NAT_W-1:0]   t,
    input  wire logic signed [COORD_W-1:0] cx,
    input  wire logic signed [COORD_W-1:0] cy,
    input  wire jac_t                      jac,
    input  wire logic signed [DET_W-1:0]   det,
    output jprod_t                         jprod,
    output lane_out_t                      res
);

    localparam logic signed [LD_W-1:0] ONE_LD    = 19'sd65536;
    localparam logic [2*AB_W-1:0]      SHAPE_RND = 36'd131072;

    logic signed [LD_W-1:0]    a_full;
    logic signed [LD_W-1:0]    b_full;
    logic [AB_W-1:0]           a1_reg;
    logic [AB_W-1:0]           b1_reg;
    logic signed [LD_W-1:0]    dns1_reg;
    logic signed [LD_W-1:0]    dnt1_reg;
    logic signed [COORD_W-1:0] cx1_reg;
    logic signed [COORD_W-1:0] cy1_reg;
    jprod_t                    jp2_reg;
    logic [2*AB_W-1:0]         ab2_reg;
    logic signed [LD_W-1:0]    dns2_reg;
    logic signed [LD_W-1:0]    dnt2_reg;
    logic [2*AB_W-1:0]         ab_rnd;
    logic [SHAPE_W-1:0]        shape3_reg;
    logic [SHAPE_W-1:0]        shape4_reg;
    logic [SHAPE_W-1:0]        shape5_reg;
    logic [SHAPE_W-1:0]        shape6_reg;
    logic [SHAPE_W-1:0]        shape7_reg;
    logic signed [LD_W-1:0]    dns3_reg;
    logic signed [LD_W-1:0]    dnt3_reg;
    logic signed [LD_W-1:0]    dns4_reg;
    logic signed [LD_W-1:0]    dnt4_reg;
    logic signed [NP_W-1:0]    mxa5_reg;
    logic signed [NP_W-1:0]    mxb5_reg;
    logic signed [NP_W-1:0]    mya5_reg;
    logic signed [NP_W-1:0]    myb5_reg;
    logic signed [NP_W-1:0]    nx6_reg;
    logic signed [NP_W-1:0]    ny6_reg;
    logic signed [NP_W-1:0]    nx7_reg;
    logic signed [NP_W-1:0]    ny7_reg;
    logic [NP_W-1:0]           nx_mag;
    logic [NP_W-1:0]           ny_mag;
    logic [DETO_W-1:0]         det_mag;
    logic [NP_W-1:0]           ax_sum;
    logic [NP_W-1:0]           ay_sum;
    lane_out_t                 res_next;
    lane_out_t                 res_reg;

    always_comb
    begin
        a_full = node_s_neg(node_id) ? ONE_LD - LD_W'(s) : ONE_LD + LD_W'(s);
        b_full = node_t_neg(node_id) ? ONE_LD - LD_W'(t) : ONE_LD + LD_W'(t);
    end

    always_comb
    begin
        ab_rnd = ab2_reg + SHAPE_RND;
    end

    always_comb
    begin
        nx_mag  = nx7_reg[NP_W-1] ? NP_W'(-nx7_reg) : NP_W'(nx7_reg);
        ny_mag  = ny7_reg[NP_W-1] ? NP_W'(-ny7_reg) : NP_W'(ny7_reg);
        det_mag = det[DET_W-1] ? DETO_W'(-det) : DETO_W'(det);
        ax_sum  = nx_mag + NP_W'({det_mag, 1'b0});
        ay_sum  = ny_mag + NP_W'({det_mag, 1'b0});
        res_next.shape = shape7_reg;
        res_next.negx  = nx7_reg[NP_W-1] != det[DET_W-1];
        res_next.negy  = ny7_reg[NP_W-1] != det[DET_W-1];
        // zero numerator on a singular element so the quotient comes out zero
        res_next.ax    = (det == '0) ? '0 : ax_sum[NUM_W-1:0];
        res_next.ay    = (det == '0) ? '0 : ay_sum[NUM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg     <= a_full[AB_W-1:0];
            b1_reg     <= b_full[AB_W-1:0];
            dns1_reg   <= node_s_neg(node_id) ? -b_full : b_full;
            dnt1_reg   <= node_t_neg(node_id) ? -a_full : a_full;
            cx1_reg    <= cx;
            cy1_reg    <= cy;

            jp2_reg.xs <= JP_W'(cx1_reg) * JP_W'(dns1_reg);
            jp2_reg.xt <= JP_W'(cx1_reg) * JP_W'(dnt1_reg);
            jp2_reg.ys <= JP_W'(cy1_reg) * JP_W'(dns1_reg);
            jp2_reg.yt <= JP_W'(cy1_reg) * JP_W'(dnt1_reg);
            ab2_reg    <= (2*AB_W)'(a1_reg) * (2*AB_W)'(b1_reg);
            dns2_reg   <= dns1_reg;
            dnt2_reg   <= dnt1_reg;

            shape3_reg <= ab_rnd[SHAPE_W+AB_W-1:AB_W];
            dns3_reg   <= dns2_reg;
            dnt3_reg   <= dnt2_reg;

            shape4_reg <= shape3_reg;
            dns4_reg   <= dns3_reg;
            dnt4_reg   <= dnt3_reg;

            mxa5_reg   <= NP_W'(dns4_reg) * NP_W'(jac.yt);
            mxb5_reg   <= NP_W'(dnt4_reg) * NP_W'(jac.ys);
            mya5_reg   <= NP_W'(dnt4_reg) * NP_W'(jac.xs);
            myb5_reg   <= NP_W'(dns4_reg) * NP_W'(jac.xt);
            shape5_reg <= shape4_reg;

            nx6_reg    <= mxa5_reg - mxb5_reg;
            ny6_reg    <= mya5_reg - myb5_reg;
            shape6_reg <= shape5_reg;

            nx7_reg    <= nx6_reg;
            ny7_reg    <= ny6_reg;
            shape7_reg <= shape6_reg;

            res_reg    <= res_next;
        end
    end

    assign jprod = jp2_reg;
    assign res   = res_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/qsf_div.sv =====
// Pipelined restoring divider, rounded magnitude in, saturated signed quotient out
`default_nettype none
module qsf_div
    import qsf_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      en,
    input  wire logic [NUM_W-1:0]          num,
    input  wire logic [DEN_W-1:0]          den,
    input  wire logic                      neg,
    output logic signed [DERIV_W-1:0]      quo
);

    localparam logic [DERIV_W-1:0] Q_MAX = {1'b0, {(DERIV_W-1){1'b1}}};
    localparam logic [DERIV_W-1:0] Q_MIN = {1'b1, {(DERIV_W-1){1'b0}}};

    logic [DEN_W-1:0]     rem_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] lo_reg  [DIV_STEPS];
    logic [DEN_W-1:0]     den_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] q_reg   [DIV_STEPS];
    logic                 sat_reg [DIV_STEPS+1];
    logic                 neg_reg [DIV_STEPS+1];
    logic [DEN_W:0]       r2_w    [DIV_STEPS];
    logic [DEN_W:0]       diff_w  [DIV_STEPS];
    logic                 ge_w    [DIV_STEPS];
    logic [DIV_STEPS-1:0] q_fin;
    logic [DERIV_W-1:0]   quo_next;
    logic [DERIV_W-1:0]   quo_reg;

    // Quotient of 2^40 or more saturates whatever the sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= DEN_W'(num[NUM_W-1:DIV_STEPS]);
            lo_reg[0]  <= num[DIV_STEPS-1:0];
            den_reg[0] <= den;
            sat_reg[0] <= DEN_W'(num[NUM_W-1:DIV_STEPS]) >= den;
            neg_reg[0] <= neg;
        end
    end

    for (genvar i = 1; i <= DIV_STEPS; i++)
    begin : g_step
        always_comb
        begin
            r2_w[i-1]   = {rem_reg[i-1], lo_reg[i-1][DIV_STEPS-1]};
            diff_w[i-1] = r2_w[i-1] - {1'b0, den_reg[i-1]};
            ge_w[i-1]   = r2_w[i-1] >= {1'b0, den_reg[i-1]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sat_reg[i] <= sat_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
            end
        end

        if (i < DIV_STEPS)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= ge_w[i-1] ? diff_w[i-1][DEN_W-1:0] : r2_w[i-1][DEN_W-1:0];
                    lo_reg[i]  <= {lo_reg[i-1][DIV_STEPS-2:0], 1'b0};
                    den_reg[i] <= den_reg[i-1];
                end
            end
        end

        if (i == 1)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    q_reg[0] <= {{(DIV_STEPS-1){1'b0}}, ge_w[0]};
                end
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    q_reg[i-1] <= {q_reg[i-2][DIV_STEPS-2:0], ge_w[i-1]};
                end
            end
        end
    end

    always_comb
    begin
        q_fin = q_reg[DIV_STEPS-1];
        if (!neg_reg[DIV_STEPS])
        begin
            quo_next = (sat_reg[DIV_STEPS] || q_fin[DIV_STEPS-1]) ? Q_MAX : DERIV_W'(q_fin);
        end
        else if (sat_reg[DIV_STEPS] || (q_fin[DIV_STEPS-1] && (|q_fin[DIV_STEPS-2:0])))
        begin
            quo_next = Q_MIN;
        end
        else
        begin
            quo_next = DERIV_W'(0) - DERIV_W'(q_fin);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= quo_next;
        end
    end

    assign quo = signed'(quo_reg);

endmodule
`default_nettype wire
